@@ src/cleb_pkg.sv @@
// ============================================================================
// cleb_pkg - shared definitions for the console line edit buffer
// Character codes, result codes, register map and default sizing.
// ============================================================================
`timescale 1ns / 1ps

package cleb_pkg;

	// Default ring depth in bytes.
	localparam int DEFAULT_BUF_DEPTH = 128;

	// Configuration port sizing.
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	// Register indexes.
	localparam logic REG_CR_MODE = 1'b0;

	// Control characters.
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_CTRL_D = 8'h04;
	localparam logic [7:0] CH_CTRL_H = 8'h08;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_CTRL_U = 8'h15;
	localparam logic [7:0] CH_DEL    = 8'h7f;

	// Largest erase count that the result word can carry.
	localparam int ERASE_MAX = 255;

	// Operation of an input word.
	typedef enum logic {
		OP_RX   = 1'b0,
		OP_READ = 1'b1
	} op_t;

	// Carriage return handling.
	typedef enum logic {
		CR_DROP      = 1'b0,
		CR_TO_NEWLINE = 1'b1
	} cr_mode_t;

	// Echo request in a result word.
	typedef enum logic [1:0] {
		ECHO_NONE  = 2'd0,
		ECHO_CHAR  = 2'd1,
		ECHO_ERASE = 2'd2
	} echo_kind_t;

	// Outcome of a read request.
	typedef enum logic [2:0] {
		RD_BYTE     = 3'd0,
		RD_NEWLINE  = 3'd1,
		RD_EOF      = 3'd2,
		RD_EOF_HELD = 3'd3,
		RD_EMPTY    = 3'd4
	} read_status_t;

endpackage

@@ src/console_line_edit_buffer.sv @@
// ============================================================================
// console_line_edit_buffer - line-editing receive ring for a console
// Stores and echoes received characters, handles erase, kill and commit,
// and hands committed bytes to a reader one at a time.
// ============================================================================
// Usage:
// The input channel (in_valid, in_stall) carries one word per event: either
// a character received from the UART (operation 0, rx_char) or a request to
// read one byte (operation 1, first_of_read marks the first byte of a call).
// Every accepted word produces exactly one result word on the output channel
// (out_valid, out_stall): the echo request, the erase count, the line-ready
// wake flag, and for reads the status and the delivered byte.
// The result word is registered: it sits in the output register at the
// edge after the input word is accepted. Throughput is one word per cycle
// unless the output stalls; the ring pointers are updated together, and the
// byte at the read pointer is kept in a prefetch register that follows every
// pointer move and every write to that slot, so a read never waits on the
// store's read port. When the receiver stalls, the result word holds and
// in_stall rises only while the output register is occupied and stalled.
// Reset clears the read, commit and edit pointers and the carriage return
// mode, and empties the output register. The byte store is not cleared.
// The cr_mode register (APB, address 0) selects whether a carriage return is
// dropped (0) or turned into a newline (1); write it only while idle.
// ============================================================================
`timescale 1ns / 1ps

module console_line_edit_buffer #(
	parameter int BUF_DEPTH = cleb_pkg::DEFAULT_BUF_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,

	// Input channel.
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            operation,
	input  logic [7:0]                      rx_char,
	input  logic                            first_of_read,

	// Output channel.
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      echo_kind,
	output logic [7:0]                      echo_char,
	output logic [7:0]                      erase_count,
	output logic                            line_ready,
	output logic [2:0]                      read_status,
	output logic [7:0]                      read_byte,

	// Configuration port.
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cleb_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [cleb_pkg::APB_DATA_W-1:0] pwdata,
	output logic [cleb_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);

	// Pointers count modulo twice the depth; the slot is the pointer modulo the depth.
	localparam int AW      = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int PTR_W   = $clog2(2 * BUF_DEPTH);
	localparam int PTR_MOD = 2 * BUF_DEPTH;
	localparam int CNT_W   = (PTR_W > 8) ? PTR_W : 8;

	localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(PTR_MOD - 1);
	localparam logic [PTR_W-1:0] PTR_DEPTH  = PTR_W'(BUF_DEPTH);
	localparam logic [PTR_W-1:0] PTR_NEARLY = PTR_W'(BUF_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(cleb_pkg::ERASE_MAX);

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_LAST : p - 1'b1;
	endfunction

	function automatic logic [PTR_W-1:0] ptr_diff(input logic [PTR_W-1:0] a,
	                                              input logic [PTR_W-1:0] b);
		logic [PTR_W:0] d;
		d = (a >= b) ? ({1'b0, a} - {1'b0, b})
		             : ({1'b0, a} + (PTR_W+1)'(PTR_MOD) - {1'b0, b});
		return d[PTR_W-1:0];
	endfunction

	function automatic logic [AW-1:0] ptr_slot(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] s;
		s = (p >= PTR_DEPTH) ? p - PTR_DEPTH : p;
		return s[AW-1:0];
	endfunction

	// State.
	logic [7:0]       line_store [BUF_DEPTH];
	logic [PTR_W-1:0] rd_ptr_q, cm_ptr_q, ed_ptr_q;
	logic             cr_mode_q;
	logic [7:0]       rd_data_q;

	// Output register.
	logic             out_valid_q;
	logic [1:0]       echo_kind_q;
	logic [7:0]       echo_char_q;
	logic [7:0]       erase_count_q;
	logic             line_ready_q;
	logic [2:0]       read_status_q;
	logic [7:0]       read_byte_q;

	// Next-state and result logic.
	logic             in_acc;
	logic [PTR_W-1:0] rd_ptr_d, cm_ptr_d, ed_ptr_d;
	logic             st_we;
	logic [AW-1:0]    st_waddr;
	logic [AW-1:0]    st_raddr;
	logic [7:0]       st_wdata;
	logic [7:0]       ch;
	logic [PTR_W-1:0] ed_inc;
	logic [PTR_W-1:0] kill_n;
	logic [CNT_W-1:0] kill_ext;
	logic             keep;
	logic [1:0]       r_echo_kind;
	logic [7:0]       r_echo_char;
	logic [7:0]       r_erase_count;
	logic             r_line_ready;
	logic [2:0]       r_read_status;
	logic [7:0]       r_read_byte;

	// Handshake: stall only when a finished word is waiting and stalled.
	assign in_stall  = out_valid_q && out_stall;
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == cleb_pkg::REG_CR_MODE)
	              ? cleb_pkg::APB_DATA_W'(cr_mode_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_mode_q <= cleb_pkg::CR_DROP;
		end else if (psel && penable && pwrite && pready &&
		             paddr[2] == cleb_pkg::REG_CR_MODE) begin
			cr_mode_q <= pwdata[0];
		end
	end

	// One pass over the word: edit, commit or read, and build the result.
	always_comb begin
		rd_ptr_d      = rd_ptr_q;
		cm_ptr_d      = cm_ptr_q;
		ed_ptr_d      = ed_ptr_q;
		st_we         = 1'b0;
		st_waddr      = ptr_slot(ed_ptr_q);
		ch            = rx_char;
		ed_inc        = ptr_inc(ed_ptr_q);
		kill_n        = ptr_diff(ed_ptr_q, cm_ptr_q);
		kill_ext      = CNT_W'(kill_n);
		keep          = 1'b1;
		r_echo_kind   = cleb_pkg::ECHO_NONE;
		r_echo_char   = '0;
		r_erase_count = '0;
		r_line_ready  = 1'b0;
		r_read_status = cleb_pkg::RD_EMPTY;
		r_read_byte   = '0;

		if (operation == cleb_pkg::OP_RX) begin
			if (rx_char == cleb_pkg::CH_CTRL_U) begin
				// Kill the whole uncommitted region.
				ed_ptr_d = cm_ptr_q;
				if (kill_n != '0) begin
					r_echo_kind   = cleb_pkg::ECHO_ERASE;
					r_erase_count = (kill_ext > CNT_MAX) ? 8'(CNT_MAX) : 8'(kill_ext);
				end
			end else if (rx_char == cleb_pkg::CH_CTRL_H || rx_char == cleb_pkg::CH_DEL) begin
				// Erase one uncommitted character.
				if (ed_ptr_q != cm_ptr_q) begin
					ed_ptr_d      = ptr_dec(ed_ptr_q);
					r_echo_kind   = cleb_pkg::ECHO_ERASE;
					r_erase_count = 8'd1;
				end
			end else if (rx_char != cleb_pkg::CH_NUL &&
			             ptr_diff(ed_ptr_q, rd_ptr_q) < PTR_DEPTH) begin
				// Plain character with room in the ring.
				if (rx_char == cleb_pkg::CH_CR) begin
					if (cr_mode_q == cleb_pkg::CR_DROP) begin
						keep = 1'b0;
					end else begin
						ch = cleb_pkg::CH_LF;
					end
				end
				if (keep) begin
					r_echo_kind = cleb_pkg::ECHO_CHAR;
					r_echo_char = ch;
					st_we       = 1'b1;
					ed_ptr_d    = ed_inc;
					if (ch == cleb_pkg::CH_LF || ch == cleb_pkg::CH_CTRL_D ||
					    ptr_diff(ed_ptr_q, rd_ptr_q) == PTR_NEARLY) begin
						r_line_ready = (cm_ptr_q != ed_inc);
						cm_ptr_d     = ed_inc;
					end
				end
			end
		end else begin
			// Read one committed byte from the prefetch register.
			if (rd_ptr_q != cm_ptr_q) begin
				if (rd_data_q == cleb_pkg::CH_CTRL_D) begin
					if (first_of_read) begin
						rd_ptr_d      = ptr_inc(rd_ptr_q);
						r_read_status = cleb_pkg::RD_EOF;
					end else begin
						r_read_status = cleb_pkg::RD_EOF_HELD;
					end
				end else begin
					rd_ptr_d      = ptr_inc(rd_ptr_q);
					r_read_byte   = rd_data_q;
					r_read_status = (rd_data_q == cleb_pkg::CH_LF)
					              ? cleb_pkg::RD_NEWLINE : cleb_pkg::RD_BYTE;
				end
			end
		end

		st_wdata = ch;
		st_raddr = ptr_slot(in_acc ? rd_ptr_d : rd_ptr_q);
	end

	// Pointer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			cm_ptr_q <= '0;
			ed_ptr_q <= '0;
		end else if (in_acc) begin
			rd_ptr_q <= rd_ptr_d;
			cm_ptr_q <= cm_ptr_d;
			ed_ptr_q <= ed_ptr_d;
		end
	end

	// Byte store with a prefetch register that always holds the byte at the
	// read pointer; a write to that same slot is forwarded.
	always_ff @(posedge clk) begin
		if (in_acc && st_we) begin
			line_store[st_waddr] <= st_wdata;
		end
		if (in_acc && st_we && st_waddr == st_raddr) begin
			rd_data_q <= st_wdata;
		end else begin
			rd_data_q <= line_store[st_raddr];
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			echo_kind_q   <= r_echo_kind;
			echo_char_q   <= r_echo_char;
			erase_count_q <= r_erase_count;
			line_ready_q  <= r_line_ready;
			read_status_q <= r_read_status;
			read_byte_q   <= r_read_byte;
		end
	end

	assign echo_kind   = echo_kind_q;
	assign echo_char   = echo_char_q;
	assign erase_count = erase_count_q;
	assign line_ready  = line_ready_q;
	assign read_status = read_status_q;
	assign read_byte   = read_byte_q;

	// The edit pointer never runs more than a full ring ahead of the reader.
	a_ring_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_diff(ed_ptr_q, rd_ptr_q) <= PTR_DEPTH)
		else $error("edit pointer ran past a full ring");

	// Committed bytes always lie between the reader and the edit pointer.
	a_commit_order: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_diff(cm_ptr_q, rd_ptr_q) <= ptr_diff(ed_ptr_q, rd_ptr_q))
		else $error("commit pointer outside the filled region");

	// A wake-up only comes with the echo of the committing character.
	a_wake_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && line_ready_q) |-> (echo_kind_q == cleb_pkg::ECHO_CHAR))
		else $error("line ready without a character echo");

	// A result word never carries both an echo and a read outcome.
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && read_status_q != cleb_pkg::RD_EMPTY)
		|-> (echo_kind_q == cleb_pkg::ECHO_NONE))
		else $error("read outcome mixed with an echo");

	// A delivered word with nothing behind it empties the output register.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall && !in_acc) |=> !out_valid_q)
		else $error("output word repeated");

endmodule
